[rtl/two_process_cpu_scheduler_assert.svh]
// assertion helpers for the two-process scheduler
`ifndef TWO_PROCESS_CPU_SCHEDULER_ASSERT_SVH
`define TWO_PROCESS_CPU_SCHEDULER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TPCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication, checked out of reset
`define TPCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

[rtl/tpcs_pkg.sv]
package tpcs_pkg;

  localparam int COUNT_WIDTH = 8;

  localparam int CFG_WIDTH = 8;
  localparam int CFG_INDEX_WIDTH = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE          = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUANTUM       = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_P1_FIRST_CPU  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_P1_IO         = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_P1_SECOND_CPU = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_P2_FIRST_CPU  = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_P2_IO         = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_P2_SECOND_CPU = 3'd7;

  // policy codes
  localparam logic [1:0] MODE_FCFS = 2'd0;
  localparam logic [1:0] MODE_SJF  = 2'd1;
  localparam logic [1:0] MODE_RR   = 2'd2;

  // process phase codes
  localparam logic [1:0] PH_READY = 2'd0;
  localparam logic [1:0] PH_RUN   = 2'd1;
  localparam logic [1:0] PH_WAIT  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [CFG_WIDTH-1:0] quantum;
    logic [CFG_WIDTH-1:0] p1_first_cpu;
    logic [CFG_WIDTH-1:0] p1_io;
    logic [CFG_WIDTH-1:0] p1_second_cpu;
    logic [CFG_WIDTH-1:0] p2_first_cpu;
    logic [CFG_WIDTH-1:0] p2_io;
    logic [CFG_WIDTH-1:0] p2_second_cpu;
  } cfg_t;

  typedef struct packed {
    logic [1:0] one_phase;
    logic [1:0] two_phase;
    cnt_t       one_cpu_left;
    cnt_t       two_cpu_left;
    cnt_t       one_io_left;
    cnt_t       two_io_left;
    cnt_t       slice_left;
  } sched_t;

  typedef struct packed {
    logic [1:0] proc_one_state;
    logic [1:0] proc_two_state;
    logic       all_finished;
  } res_t;

  // register value into a counter, masked to the counter width
  function automatic cnt_t to_cnt(input logic [CFG_WIDTH-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[COUNT_WIDTH-1:0];
  endfunction

  function automatic cnt_t dec_sat(input cnt_t v);
    return (v == '0) ? '0 : v - cnt_t'(1);
  endfunction

  function automatic sched_t reload(input cfg_t c);
    sched_t s;
    s.one_phase    = PH_READY;
    s.two_phase    = PH_READY;
    s.one_cpu_left = to_cnt(c.p1_first_cpu);
    s.two_cpu_left = to_cnt(c.p2_first_cpu);
    s.one_io_left  = to_cnt(c.p1_io);
    s.two_io_left  = to_cnt(c.p2_io);
    s.slice_left   = to_cnt(c.quantum);
    return s;
  endfunction

endpackage

[rtl/two_process_cpu_scheduler.sv]
// Two-process cpu scheduler advanced one tick per input beat. Each process runs a first cpu
// burst, an io burst and a second cpu burst, then is done; a zero io length ends it after
// the first burst. Every input beat is one tick and yields exactly one output beat with both
// process states (0 ready, 1 running, 2 waiting, 3 done) and an all-finished flag.
// cfg_index selects the register: 0 mode (0 fcfs, 1 sjf, 2 round robin, 3 acts as fcfs), 1
// quantum, 2..4 process one first cpu, io, second cpu, 5..7 the same for process two;
// writes are registered, mode acts from the next tick and the rest at the next reload
// (restart, io end, dispatch or handover). Setting in_restart reloads both processes from
// the registers before that tick. Throughput is one tick per clock while in_stall is low:
// the tick update is combinational between the state registers and the output register.
// The output register decouples the sides: a new beat is taken while the held result is
// being drained, and in_stall rises only when that result is held stalled.
`include "two_process_cpu_scheduler_assert.svh"

module two_process_cpu_scheduler (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [tpcs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [tpcs_pkg::CFG_WIDTH-1:0]       cfg_wdata,
  // tick input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_restart,
  // state report
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            out_proc_one_state,
  output logic [1:0]                            out_proc_two_state,
  output logic                                  out_all_finished
);

  tpcs_pkg::cfg_t   cfg_r;
  tpcs_pkg::cfg_t   cfg_rst;
  tpcs_pkg::sched_t state_r;
  tpcs_pkg::sched_t state_nxt;
  tpcs_pkg::res_t   res_nxt;
  tpcs_pkg::res_t   res_r;
  logic             out_valid_r;
  logic             in_accept;
  logic             rep_both_run;
  logic             rep_both_done;

  // reset register image
  always_comb begin
    cfg_rst.mode          = tpcs_pkg::MODE_FCFS;
    cfg_rst.quantum       = tpcs_pkg::CFG_WIDTH'(1);
    cfg_rst.p1_first_cpu  = tpcs_pkg::CFG_WIDTH'(1);
    cfg_rst.p1_io         = '0;
    cfg_rst.p1_second_cpu = tpcs_pkg::CFG_WIDTH'(1);
    cfg_rst.p2_first_cpu  = tpcs_pkg::CFG_WIDTH'(1);
    cfg_rst.p2_io         = '0;
    cfg_rst.p2_second_cpu = tpcs_pkg::CFG_WIDTH'(1);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cfg_rst;
    end else if (cfg_we) begin
      case (cfg_index)
        tpcs_pkg::REG_MODE:          cfg_r.mode          <= cfg_wdata[1:0];
        tpcs_pkg::REG_QUANTUM:       cfg_r.quantum       <= cfg_wdata;
        tpcs_pkg::REG_P1_FIRST_CPU:  cfg_r.p1_first_cpu  <= cfg_wdata;
        tpcs_pkg::REG_P1_IO:         cfg_r.p1_io         <= cfg_wdata;
        tpcs_pkg::REG_P1_SECOND_CPU: cfg_r.p1_second_cpu <= cfg_wdata;
        tpcs_pkg::REG_P2_FIRST_CPU:  cfg_r.p2_first_cpu  <= cfg_wdata;
        tpcs_pkg::REG_P2_IO:         cfg_r.p2_io         <= cfg_wdata;
        tpcs_pkg::REG_P2_SECOND_CPU: cfg_r.p2_second_cpu <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // take a beat unless the held result is stalled
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // one tick of scheduling
  tpcs_tick u_tick (
    .cur     (state_r),
    .cfg     (cfg_r),
    .restart (in_restart),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  // scheduler state, reset matches a reload from the reset register image
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpcs_pkg::reload(cfg_rst);
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_proc_one_state = res_r.proc_one_state;
  assign out_proc_two_state = res_r.proc_two_state;
  assign out_all_finished   = res_r.all_finished;

  // reported-state summaries for the checks below
  assign rep_both_run  = (res_r.proc_one_state == tpcs_pkg::PH_RUN) &&
                         (res_r.proc_two_state == tpcs_pkg::PH_RUN);
  assign rep_both_done = (res_r.proc_one_state == tpcs_pkg::PH_DONE) &&
                         (res_r.proc_two_state == tpcs_pkg::PH_DONE);

  // at most one process holds the cpu in any reported beat
  `TPCS_ASSERT_NOW(a_one_runner, out_valid_r, !rep_both_run)
  // finished flag agrees with the reported states
  `TPCS_ASSERT_NOW(a_finished_flag, out_valid_r, out_all_finished == rep_both_done)
  // scheduler state only moves on an accepted beat
  `TPCS_ASSERT_NEXT(a_state_hold, !in_accept, $stable(state_r))

endmodule

[rtl/tpcs_tick.sv]
module tpcs_tick (
  input  tpcs_pkg::sched_t cur,
  input  tpcs_pkg::cfg_t   cfg,
  input  logic             restart,
  output tpcs_pkg::sched_t nxt,
  output tpcs_pkg::res_t   res
);

  tpcs_pkg::sched_t s;
  logic             busy;

  always_comb begin
    s = restart ? tpcs_pkg::reload(cfg) : cur;
    busy = !(s.one_phase == tpcs_pkg::PH_DONE && s.two_phase == tpcs_pkg::PH_DONE);

    if (busy) begin
      // burst end, process one first
      if (s.one_phase == tpcs_pkg::PH_RUN && s.one_cpu_left == '0) begin
        s.one_phase = (s.one_io_left == '0) ? tpcs_pkg::PH_DONE : tpcs_pkg::PH_WAIT;
      end else if (s.two_phase == tpcs_pkg::PH_RUN && s.two_cpu_left == '0) begin
        s.two_phase = (s.two_io_left == '0) ? tpcs_pkg::PH_DONE : tpcs_pkg::PH_WAIT;
      end

      // slice expiry, cpu handed over only to a ready peer
      if (cfg.mode == tpcs_pkg::MODE_RR) begin
        if (s.one_phase == tpcs_pkg::PH_RUN && s.slice_left == '0) begin
          s.one_phase = tpcs_pkg::PH_READY;
          if (s.two_phase == tpcs_pkg::PH_READY) begin
            s.two_phase  = tpcs_pkg::PH_RUN;
            s.slice_left = tpcs_pkg::to_cnt(cfg.quantum);
          end
        end
        if (s.two_phase == tpcs_pkg::PH_RUN && s.slice_left == '0) begin
          s.two_phase = tpcs_pkg::PH_READY;
          if (s.one_phase == tpcs_pkg::PH_READY) begin
            s.one_phase  = tpcs_pkg::PH_RUN;
            s.slice_left = tpcs_pkg::to_cnt(cfg.quantum);
          end
        end
      end

      // io end loads the second burst
      if (s.one_phase == tpcs_pkg::PH_WAIT && s.one_io_left == '0) begin
        s.one_phase    = tpcs_pkg::PH_READY;
        s.one_cpu_left = tpcs_pkg::to_cnt(cfg.p1_second_cpu);
      end
      if (s.two_phase == tpcs_pkg::PH_WAIT && s.two_io_left == '0) begin
        s.two_phase    = tpcs_pkg::PH_READY;
        s.two_cpu_left = tpcs_pkg::to_cnt(cfg.p2_second_cpu);
      end

      // dispatch
      if (s.one_phase == tpcs_pkg::PH_READY && s.two_phase == tpcs_pkg::PH_READY) begin
        if (cfg.mode == tpcs_pkg::MODE_SJF && s.one_cpu_left > s.two_cpu_left) begin
          s.two_phase = tpcs_pkg::PH_RUN;
        end else begin
          s.one_phase = tpcs_pkg::PH_RUN;
        end
        s.slice_left = tpcs_pkg::to_cnt(cfg.quantum);
      end else if (s.one_phase == tpcs_pkg::PH_READY && s.two_phase != tpcs_pkg::PH_RUN) begin
        s.one_phase  = tpcs_pkg::PH_RUN;
        s.slice_left = tpcs_pkg::to_cnt(cfg.quantum);
      end else if (s.two_phase == tpcs_pkg::PH_READY && s.one_phase != tpcs_pkg::PH_RUN) begin
        s.two_phase  = tpcs_pkg::PH_RUN;
        s.slice_left = tpcs_pkg::to_cnt(cfg.quantum);
      end
    end

    res.proc_one_state = s.one_phase;
    res.proc_two_state = s.two_phase;
    res.all_finished   = (s.one_phase == tpcs_pkg::PH_DONE) &&
                         (s.two_phase == tpcs_pkg::PH_DONE);

    // count down after reporting
    nxt = s;
    if (!res.all_finished) begin
      nxt.slice_left = tpcs_pkg::dec_sat(s.slice_left);
      if (s.one_phase == tpcs_pkg::PH_RUN) nxt.one_cpu_left = tpcs_pkg::dec_sat(s.one_cpu_left);
      if (s.one_phase == tpcs_pkg::PH_WAIT) nxt.one_io_left = tpcs_pkg::dec_sat(s.one_io_left);
      if (s.two_phase == tpcs_pkg::PH_RUN) nxt.two_cpu_left = tpcs_pkg::dec_sat(s.two_cpu_left);
      if (s.two_phase == tpcs_pkg::PH_WAIT) nxt.two_io_left = tpcs_pkg::dec_sat(s.two_io_left);
    end
  end

endmodule
